FILE: hdl/c8ic_pkg.sv
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared types, codes and tables for the chip8 instruction core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

  // default sizes
  localparam int unsigned MEM_BYTES_DEF   = 4096;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // fixed machine constants
  localparam int unsigned SCREEN_WIDTH  = 64;
  localparam int unsigned SCREEN_HEIGHT = 32;
  localparam int unsigned BUTTON_COUNT  = 6;
  localparam int unsigned FONT_BYTES    = 80;
  localparam logic [11:0] PC_RESET      = 12'h200;
  localparam logic [23:0] KEYS_RESET    = 24'h543210;
  localparam logic [7:0]  DEC_HUNDRED   = 8'd100;
  localparam logic [7:0]  DEC_TEN       = 8'd10;

  // item operation codes
  localparam logic [1:0] OPER_WRITE = 2'd0;
  localparam logic [1:0] OPER_EXEC  = 2'd1;
  localparam logic [1:0] OPER_ROW   = 2'd2;

  // configuration register index
  localparam logic REG_KEYS = 1'b0;

  // instruction groups (high nibble of first byte)
  localparam logic [3:0] G_SYS  = 4'h0;
  localparam logic [3:0] G_JP   = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_SEB  = 4'h3;
  localparam logic [3:0] G_SNEB = 4'h4;
  localparam logic [3:0] G_SER  = 4'h5;
  localparam logic [3:0] G_LDB  = 4'h6;
  localparam logic [3:0] G_ADDB = 4'h7;
  localparam logic [3:0] G_ALU  = 4'h8;
  localparam logic [3:0] G_SNER = 4'h9;
  localparam logic [3:0] G_LDI  = 4'hA;
  localparam logic [3:0] G_JPV0 = 4'hB;
  localparam logic [3:0] G_RND  = 4'hC;
  localparam logic [3:0] G_DRW  = 4'hD;
  localparam logic [3:0] G_KEY  = 4'hE;
  localparam logic [3:0] G_MISC = 4'hF;

  // sub codes
  localparam logic [3:0] SYS_CLS  = 4'h0;
  localparam logic [3:0] SYS_RET  = 4'hE;
  localparam logic [3:0] KEY_SKP  = 4'hE;
  localparam logic [3:0] KEY_SKNP = 4'h1;
  localparam logic [3:0] A_MOV = 4'h0;
  localparam logic [3:0] A_OR  = 4'h1;
  localparam logic [3:0] A_AND = 4'h2;
  localparam logic [3:0] A_XOR = 4'h3;
  localparam logic [3:0] A_ADD = 4'h4;
  localparam logic [3:0] A_SUB = 4'h5;
  localparam logic [3:0] A_SHR = 4'h6;
  localparam logic [3:0] A_SBN = 4'h7;
  localparam logic [3:0] A_SHL = 4'hE;
  localparam logic [7:0] M_GETDT = 8'h07;
  localparam logic [7:0] M_WKEY  = 8'h0A;
  localparam logic [7:0] M_SETDT = 8'h15;
  localparam logic [7:0] M_SETST = 8'h18;
  localparam logic [7:0] M_ADDI  = 8'h1E;
  localparam logic [7:0] M_FONT  = 8'h29;
  localparam logic [7:0] M_BCD   = 8'h33;
  localparam logic [7:0] M_STORE = 8'h55;
  localparam logic [7:0] M_LOAD  = 8'h65;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [7:0]  random_byte;
    logic [5:0]  buttons_down;
    logic [4:0]  row;
  } c8ic_item_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic [11:0] program_counter;
    logic        sound_on;
    logic        waiting_for_key;
  } c8ic_result_t;

  typedef enum logic [3:0] {
    ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL, ALU_EQ
  } c8ic_alu_op_t;

  typedef struct packed {
    logic [7:0] result;
    logic       flag;
  } c8ic_alu_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH_HI, S_FETCH_LO, S_EXEC, S_DRAW_ADDR, S_DRAW_DATA,
    S_BCD, S_STORE, S_LOAD_ADDR, S_LOAD_DATA, S_FINISH, S_RESULT
  } c8ic_state_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // fold a 12-bit address into a memory of m bytes (m at least 512)
  function automatic logic [11:0] wrap_addr(input logic [11:0] a, input int unsigned m);
    int unsigned v;
    v = 32'(a);
    if (v >= 4 * m) v = v - 4 * m;
    if (v >= 2 * m) v = v - 2 * m;
    if (v >= m) v = v - m;
    return v[11:0];
  endfunction

endpackage

FILE: hdl/c8ic_ram.sv
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8ic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/c8ic_alu.sv
// ----------------------------------------------------------------------------
// c8ic_alu
// Shared 8-bit arithmetic, logic, shift and compare unit.
// ----------------------------------------------------------------------------
module c8ic_alu (
  input  logic [7:0]             a,
  input  logic [7:0]             b,
  input  c8ic_pkg::c8ic_alu_op_t op,
  output c8ic_pkg::c8ic_alu_out_t res
);
  import c8ic_pkg::*;

  logic [8:0] sum;
  logic [8:0] dif;

  assign sum = {1'b0, a} + {1'b0, b};
  assign dif = {1'b0, a} - {1'b0, b};

  // operation select
  always_comb begin
    res.result = b;
    res.flag   = 1'b0;
    unique case (op)
      ALU_PASS: res.result = b;
      ALU_OR:   res.result = a | b;
      ALU_AND:  res.result = a & b;
      ALU_XOR:  res.result = a ^ b;
      ALU_ADD: begin
        res.result = sum[7:0];
        res.flag   = sum[8];
      end
      ALU_SUB: begin
        res.result = dif[7:0];
        res.flag   = ~dif[8];
      end
      ALU_SHR: begin
        res.result = {1'b0, a[7:1]};
        res.flag   = a[0];
      end
      ALU_SHL: begin
        res.result = {a[6:0], 1'b0};
        res.flag   = a[7];
      end
      ALU_EQ: begin
        res.result = a;
        res.flag   = (a == b);
      end
      default: res.result = b;
    endcase
  end

endmodule

FILE: hdl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 core: program memory, registers, stack, timers and frame buffer,
// run one item at a time by a small sequencer around a shared 8-bit unit.
//
//   channel  | direction | handshake                  | payload
//   item     | in        | item_valid / item_stall    | c8ic_item_t
//   result   | out       | result_valid / result_stall| c8ic_result_t
//   config   | in        | APB psel/penable/pready    | button_key_codes
//
// write byte, read row and unused codes go straight to the result state; an
// execute runs fetch high, fetch low, execute, finish, result; a draw adds an
// address and a data step per sprite row, FX55 a store per register, FX65 an
// address and a data step per register, FX33 its BCD steps, set by the single
// registered read port of memory and the shared 8-bit unit. a clearing pass
// after reset loads the font and zeroes memory; no item is taken during it.
// a result waiting in the output register does not hold back the next item.
// ----------------------------------------------------------------------------
module chip8_instruction_core #(
  parameter int unsigned MEM_BYTES   = c8ic_pkg::MEM_BYTES_DEF,
  parameter int unsigned STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  c8ic_pkg::c8ic_item_t  item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output c8ic_pkg::c8ic_result_t result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import c8ic_pkg::*;

  localparam int unsigned AW  = $clog2(MEM_BYTES);
  localparam int unsigned SPW = $clog2(STACK_DEPTH);

  c8ic_state_t state, state_next;

  logic [23:0]      keys;
  logic [11:0]      pc, ir, npc;
  logic [SPW-1:0]   sp, sp_inc, sp_dec;
  logic [7:0]       vreg [16];
  logic [11:0]      stack [STACK_DEPTH];
  logic [7:0]       delay, sound;
  logic [63:0]      frame [SCREEN_HEIGHT];
  logic [AW-1:0]    clr;
  c8ic_item_t       item_r;
  logic [7:0]       hi, lo;
  logic [3:0]       cnt;
  logic [1:0]       phase;
  logic [7:0]       work, wa, wb;
  logic [63:0]      pix;
  logic             wait_r;

  logic             accept;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [7:0]       alu_a, alu_b;
  c8ic_alu_op_t     alu_op;
  c8ic_alu_out_t    alu_res;

  logic [3:0]       grp, xi, yi, nib;
  logic [11:0]      nnn;
  logic [7:0]       vx, vy;
  logic             key_found, key_hit;
  logic [3:0]       key_first;
  logic [4:0]       draw_row, frame_sel;
  logic [63:0]      frame_rd, draw_mask;
  logic [127:0]     draw_rot;

  function automatic logic [AW-1:0] maddr(input logic [11:0] a);
    logic [11:0] w;
    w = wrap_addr(a, MEM_BYTES);
    return w[AW-1:0];
  endfunction

  // instruction fields
  assign grp = hi[7:4];
  assign xi  = hi[3:0];
  assign yi  = lo[7:4];
  assign nib = lo[3:0];
  assign nnn = {xi, lo};
  assign vx  = vreg[xi];
  assign vy  = vreg[yi];

  assign sp_inc = (sp == SPW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SPW'(STACK_DEPTH - 1) : sp - 1'b1;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEYS) ? {8'd0, keys} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= KEYS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_KEYS) begin
      keys <= pwdata[23:0];
    end
  end

  // button searches
  always_comb begin
    key_found = 1'b0;
    key_first = 4'd0;
    key_hit   = 1'b0;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (item_r.buttons_down[i]) begin
        key_found = 1'b1;
        key_first = keys[4*i +: 4];
      end
    end
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if ({4'd0, keys[4*i +: 4]} == vx &&
          item_r.buttons_down[i] == (nib == KEY_SKP)) begin
        key_hit = 1'b1;
      end
    end
  end

  // frame row read and sprite mask
  assign draw_row  = wb[4:0] + {1'b0, cnt};
  assign frame_sel = (state == S_DRAW_DATA) ? draw_row : item.row;
  assign frame_rd  = frame[frame_sel];
  assign draw_rot  = {ram_rdata, 56'd0, ram_rdata, 56'd0} >> wa[5:0];
  assign draw_mask = draw_rot[63:0];

  // shared unit operand select
  always_comb begin
    alu_a  = vx;
    alu_b  = lo;
    alu_op = ALU_EQ;
    if (state == S_BCD) begin
      alu_a  = work;
      alu_b  = (phase == 2'd0) ? DEC_HUNDRED : DEC_TEN;
      alu_op = ALU_SUB;
    end else begin
      case (grp)
        G_SER, G_SNER: alu_b = vy;
        G_ADDB:        alu_op = ALU_ADD;
        G_ALU: begin
          alu_b = vy;
          case (nib)
            A_OR:    alu_op = ALU_OR;
            A_AND:   alu_op = ALU_AND;
            A_XOR:   alu_op = ALU_XOR;
            A_ADD:   alu_op = ALU_ADD;
            A_SUB:   alu_op = ALU_SUB;
            A_SHR:   alu_op = ALU_SHR;
            A_SHL:   alu_op = ALU_SHL;
            A_SBN: begin
              alu_a  = vy;
              alu_b  = vx;
              alu_op = ALU_SUB;
            end
            default: alu_op = ALU_PASS;
          endcase
        end
        default: alu_op = ALU_EQ;
      endcase
    end
  end

  c8ic_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  c8ic_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = maddr(ir + {10'd0, phase});
    ram_wdata  = '0;
    ram_raddr  = maddr(ir + {8'd0, cnt});
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = (clr < AW'(FONT_BYTES)) ? FONT[clr[6:0]] : 8'd0;
        if (clr == AW'(MEM_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        ram_raddr = maddr(pc);
        ram_waddr = maddr(item.address);
        ram_wdata = item.write_data;
        if (accept) begin
          ram_we     = (item.operation == OPER_WRITE);
          state_next = (item.operation == OPER_EXEC) ? S_FETCH_HI : S_RESULT;
        end
      end
      S_FETCH_HI: begin
        ram_raddr  = maddr(pc + 12'd1);
        state_next = S_FETCH_LO;
      end
      S_FETCH_LO: state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_FINISH;
        if (grp == G_DRW && nib != 4'd0) state_next = S_DRAW_ADDR;
        if (grp == G_MISC && lo == M_BCD) state_next = S_BCD;
        if (grp == G_MISC && lo == M_STORE) state_next = S_STORE;
        if (grp == G_MISC && lo == M_LOAD) state_next = S_LOAD_ADDR;
      end
      S_DRAW_ADDR: state_next = S_DRAW_DATA;
      S_DRAW_DATA: state_next = (cnt == nib - 4'd1) ? S_FINISH : S_DRAW_ADDR;
      S_BCD: begin
        if (phase == 2'd2) begin
          ram_we     = 1'b1;
          ram_wdata  = work;
          state_next = S_FINISH;
        end else if (!alu_res.flag) begin
          ram_we    = 1'b1;
          ram_wdata = {4'd0, cnt};
        end
      end
      S_STORE: begin
        ram_we     = 1'b1;
        ram_waddr  = maddr(ir + {8'd0, cnt});
        ram_wdata  = vreg[cnt];
        if (cnt == xi) state_next = S_FINISH;
      end
      S_LOAD_ADDR: state_next = S_LOAD_DATA;
      S_LOAD_DATA: state_next = (cnt == xi) ? S_FINISH : S_LOAD_ADDR;
      S_FINISH:    state_next = S_RESULT;
      S_RESULT: begin
        if (!result_valid || !result_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // machine state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      pc    <= PC_RESET;
      ir    <= '0;
      sp    <= '0;
      delay <= '0;
      sound <= '0;
      for (int i = 0; i < 16; i++) vreg[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
      for (int i = 0; i < SCREEN_HEIGHT; i++) frame[i] <= '0;
    end else begin
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            item_r <= item;
            wait_r <= 1'b0;
            pix    <= (item.operation == OPER_ROW) ? frame_rd : 64'd0;
          end
        end
        S_FETCH_HI: hi <= ram_rdata;
        S_FETCH_LO: lo <= ram_rdata;
        S_EXEC: begin
          npc   <= pc + 12'd2;
          cnt   <= '0;
          phase <= '0;
          work  <= vx;
          case (grp)
            G_SYS: begin
              if (nib == SYS_CLS) begin
                for (int i = 0; i < SCREEN_HEIGHT; i++) frame[i] <= '0;
              end else if (nib == SYS_RET) begin
                sp  <= sp_dec;
                npc <= stack[sp_dec] + 12'd2;
              end else begin
                npc <= pc;
              end
            end
            G_JP: npc <= nnn;
            G_CALL: begin
              stack[sp] <= pc;
              sp        <= sp_inc;
              npc       <= nnn;
            end
            G_SEB, G_SER:   if (alu_res.flag) npc <= pc + 12'd4;
            G_SNEB, G_SNER: if (!alu_res.flag) npc <= pc + 12'd4;
            G_LDB:  vreg[xi] <= lo;
            G_ADDB: vreg[xi] <= alu_res.result;
            G_ALU: begin
              case (nib)
                A_MOV, A_OR, A_AND, A_XOR: vreg[xi] <= alu_res.result;
                A_ADD, A_SUB, A_SBN: begin
                  vreg[xi] <= alu_res.result;
                  vreg[15] <= {7'd0, alu_res.flag};
                end
                A_SHR, A_SHL: begin
                  if (xi == 4'hF) begin
                    // flag lands first and is then shifted itself
                    vreg[15] <= (nib == A_SHL) ? {6'd0, alu_res.flag, 1'b0} : 8'd0;
                  end else begin
                    vreg[15] <= {7'd0, alu_res.flag};
                    vreg[xi] <= alu_res.result;
                  end
                end
                default: npc <= pc;
              endcase
            end
            G_LDI:  ir <= nnn;
            G_JPV0: npc <= nnn + {4'd0, vreg[0]};
            G_RND:  vreg[xi] <= item_r.random_byte & lo;
            G_DRW: begin
              wa       <= vx;
              wb       <= vy;
              vreg[15] <= '0;
            end
            G_KEY: begin
              if (nib == KEY_SKP || nib == KEY_SKNP) begin
                if (key_hit) npc <= pc + 12'd4;
              end else begin
                npc <= pc;
              end
            end
            default: begin
              case (lo)
                M_GETDT: vreg[xi] <= delay;
                M_WKEY: begin
                  if (key_found) begin
                    vreg[xi] <= {4'd0, key_first};
                  end else begin
                    npc    <= pc;
                    wait_r <= 1'b1;
                  end
                end
                M_SETDT: delay <= vx;
                M_SETST: sound <= vx;
                M_ADDI:  ir <= ir + {4'd0, vx};
                M_FONT:  ir <= {2'd0, vx, 2'd0} + {4'd0, vx};
                M_BCD, M_STORE, M_LOAD: ;
                default: npc <= pc;
              endcase
            end
          endcase
        end
        S_DRAW_DATA: begin
          frame[draw_row] <= frame_rd ^ draw_mask;
          if (|(frame_rd & draw_mask)) vreg[15] <= 8'd1;
          cnt <= cnt + 4'd1;
        end
        S_BCD: begin
          if (alu_res.flag && phase != 2'd2) begin
            work <= alu_res.result;
            cnt  <= cnt + 4'd1;
          end else begin
            cnt   <= '0;
            phase <= phase + 2'd1;
          end
        end
        S_STORE: cnt <= cnt + 4'd1;
        S_LOAD_DATA: begin
          vreg[cnt] <= ram_rdata;
          cnt       <= cnt + 4'd1;
        end
        S_FINISH: begin
          pc <= npc;
          if (delay != 8'd0) delay <= delay - 8'd1;
          if (sound != 8'd0) sound <= sound - 8'd1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_RESULT && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!result_valid || !result_stall)) begin
      result.row_pixels      <= pix;
      result.program_counter <= pc;
      result.sound_on        <= (sound != 8'd0);
      result.waiting_for_key <= wait_r;
    end
  end

endmodule

FILE: hdl/c8ic_checker.sv
// ----------------------------------------------------------------------------
// c8ic_checker
// Port-level checks for the chip8 instruction core, bound to the top level.
// ----------------------------------------------------------------------------
module c8ic_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input c8ic_pkg::c8ic_result_t result
);
  import c8ic_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // clearing pass blocks items right after reset
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> item_stall)
    else $error("item taken during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken while busy");

  // a key wait comes only from an execute, which returns no pixels
  a_wait_no_pixels: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.waiting_for_key |-> result.row_pixels == 64'd0)
    else $error("pixels on a key wait result");

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);
